### hw/rtl/ipv4_header_validator_core_macros.svh
// ----------------------------------------------------------------------------
// IPv4 header validator assertion macros
// Shared concurrent assertion forms for the validator RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_VALIDATOR_CORE_MACROS_SVH
`define IPV4_HEADER_VALIDATOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IPV4HV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define IPV4HV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ipv4hv_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header validator package
// Types, constants and helpers shared by the validator modules.
// ----------------------------------------------------------------------------
package ipv4hv_pkg;

    // register map (word index in paddr[3:2])
    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_SUBNET_BITS = 2'd1;
    localparam logic [1:0] REG_MTU_LIMIT   = 2'd2;
    localparam int unsigned APB_ADDR_W     = 4;

    // config reset values
    localparam logic [31:0] RST_LOCAL_IP    = 32'd0;
    localparam logic [5:0]  RST_SUBNET_BITS = 6'd24;
    localparam logic [15:0] RST_MTU_LIMIT   = 16'd1500;

    // header byte offsets
    localparam logic [15:0] OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] OFS_TOTAL_HI  = 16'd2;
    localparam logic [15:0] OFS_TOTAL_LO  = 16'd3;
    localparam logic [15:0] OFS_FLAGS_HI  = 16'd6;
    localparam logic [15:0] OFS_FLAGS_LO  = 16'd7;
    localparam logic [15:0] OFS_TTL       = 16'd8;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_SRC       = 16'd12;
    localparam logic [15:0] OFS_DST       = 16'd16;
    localparam logic [15:0] OFS_HDR_END   = 16'd20;
    localparam logic [15:0] BYTE_CNT_MAX  = 16'hffff;

    // header checks
    localparam logic [5:0]  HDR_MIN_BYTES    = 6'd20;
    localparam logic [3:0]  IP_VERSION4      = 4'd4;
    localparam logic [16:0] CSUM_GOOD        = 17'h0ffff;
    localparam logic [31:0] MCAST_BASE       = 32'he000_0000;
    localparam logic [7:0]  NET_ZERO         = 8'd0;
    localparam logic [7:0]  NET_LOOPBACK     = 8'd127;
    localparam logic [5:0]  MAX_SUBNET_PFX   = 6'd30;
    localparam logic [15:0] FRAG_MASK        = 16'h3fff;
    localparam int unsigned RSV_FLAG_BIT     = 15;

    // protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        OUT_FORWARD   = 3'd0,
        OUT_INVALID   = 3'd1,
        OUT_NOT_LOCAL = 3'd2,
        OUT_BAD_SRC   = 3'd3,
        OUT_MTU       = 3'd4,
        OUT_FRAGMENT  = 3'd5,
        OUT_OPTIONS   = 3'd6,
        OUT_BAD_PROTO = 3'd7
    } t_outcome;

    typedef enum logic [1:0] {
        STG_NONE = 2'd0,
        STG_ICMP = 2'd1,
        STG_UDP  = 2'd2,
        STG_TCP  = 2'd3
    } t_stage;

    // live configuration
    typedef struct packed {
        logic [31:0] local_ip;
        logic [5:0]  subnet_bits;
        logic [15:0] mtu_limit;
    } t_cfg;

    // one captured header, handed from front to back
    typedef struct packed {
        logic [15:0] received;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [15:0] flags_ofs;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [20:0] csum_acc;
    } t_pkt_rec;

    // network mask with the top subnet_bits bits set
    function automatic logic [31:0] prefix_mask(input logic [5:0] subnet_bits);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 32; k++) begin
            m[31-k] = (6'(k) < subnet_bits);
        end
        return m;
    endfunction

endpackage

### hw/rtl/ipv4hv_if.sv
// ----------------------------------------------------------------------------
// IPv4 header validator channels
// Byte input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipv4hv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4hv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [1:0]  next_stage;
    logic        count_as_error;
    logic [15:0] forward_length;

    modport source (output valid, output outcome, output next_stage,
                    output count_as_error, output forward_length, input ready);
    modport sink   (input valid, input outcome, input next_stage,
                    input count_as_error, input forward_length, output ready);
endinterface

### hw/rtl/ipv4_header_validator_core.sv
// ----------------------------------------------------------------------------
// IPv4 header validator core
// Checks an IPv4 header byte stream and demultiplexes to ICMP/UDP/TCP.
//
//   channel  | dir | handshake     | beat payload
//   ---------+-----+---------------+----------------------------------------
//   i_byte   | in  | valid/ready   | data_byte[7:0], last_byte
//   o_result | out | valid/ready   | outcome[2:0], next_stage[1:0],
//            |     |               | count_as_error, forward_length[15:0]
//   APB      | in  | psel/penable  | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One byte beat per cycle; the front end never stalls except when the
// two-entry record queue is full. A verdict is registered in the back end
// output register after its record has passed through the queue.
// Output stalls back up into the queue, then into the byte channel.
// Synchronous active-low reset clears packet state, queue and config.
// ----------------------------------------------------------------------------
module ipv4_header_validator_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ipv4hv_byte_if.sink                            i_byte,
    ipv4hv_result_if.source                        o_result,
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [ipv4hv_pkg::APB_ADDR_W-1:0]      i_paddr,
    input  logic [31:0]                            i_pwdata,
    output logic [31:0]                            o_prdata,
    output logic                                   o_pready
);
    import ipv4hv_pkg::*;

    logic [31:0] r_local_ip;
    logic [5:0]  r_subnet_bits;
    logic [15:0] r_mtu_limit;
    logic        cfg_wr;
    t_cfg        cfg;
    logic        push, q_full, q_valid, pop;
    t_pkt_rec    push_rec, head_rec;

    // config registers
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= RST_LOCAL_IP;
            r_subnet_bits <= RST_SUBNET_BITS;
            r_mtu_limit   <= RST_MTU_LIMIT;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                REG_LOCAL_IP:    r_local_ip    <= i_pwdata;
                REG_SUBNET_BITS: r_subnet_bits <= i_pwdata[5:0];
                REG_MTU_LIMIT:   r_mtu_limit   <= i_pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // config readback
    always_comb begin
        case (i_paddr[3:2])
            REG_LOCAL_IP:    o_prdata = r_local_ip;
            REG_SUBNET_BITS: o_prdata = {26'd0, r_subnet_bits};
            REG_MTU_LIMIT:   o_prdata = {16'd0, r_mtu_limit};
            default:         o_prdata = 32'd0;
        endcase
    end

    assign cfg.local_ip    = r_local_ip;
    assign cfg.subnet_bits = r_subnet_bits;
    assign cfg.mtu_limit   = r_mtu_limit;

    ipv4hv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_q_full(q_full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    ipv4hv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_rec)
    );

    ipv4hv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_valid(q_valid),
        .i_q_head (head_rec),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

### hw/rtl/ipv4hv_front.sv
// ----------------------------------------------------------------------------
// IPv4 header validator front end
// Accepts packet bytes, captures header fields, sums header words, and
// pushes one header record per packet on the last beat.
// ----------------------------------------------------------------------------
module ipv4hv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipv4hv_byte_if.sink           i_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output ipv4hv_pkg::t_pkt_rec  o_rec
);
    import ipv4hv_pkg::*;

    logic [15:0] r_byte_idx,  n_byte_idx;
    logic [7:0]  r_ver_ihl,   n_ver_ihl;
    logic [15:0] r_total,     n_total;
    logic [15:0] r_flags,     n_flags;
    logic [7:0]  r_ttl,       n_ttl;
    logic [7:0]  r_proto,     n_proto;
    logic [31:0] r_src,       n_src;
    logic [31:0] r_dst,       n_dst;
    logic [20:0] r_csum,      n_csum;
    logic [7:0]  r_pend_hi,   n_pend_hi;
    logic [15:0] hdr_bytes;
    logic        accept;
    logic [7:0]  b;

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    // per-beat field capture and checksum accumulate
    always_comb begin
        n_ver_ihl = (r_byte_idx == OFS_VER_IHL) ? b : r_ver_ihl;
        hdr_bytes = {10'd0, n_ver_ihl[3:0], 2'b00};
        n_total   = r_total;
        n_flags   = r_flags;
        n_ttl     = r_ttl;
        n_proto   = r_proto;
        n_src     = r_src;
        n_dst     = r_dst;
        n_csum    = r_csum;
        n_pend_hi = r_pend_hi;
        case (r_byte_idx)
            OFS_TOTAL_HI: n_total = {b, r_total[7:0]};
            OFS_TOTAL_LO: n_total = {r_total[15:8], b};
            OFS_FLAGS_HI: n_flags = {b, r_flags[7:0]};
            OFS_FLAGS_LO: n_flags = {r_flags[15:8], b};
            OFS_TTL:      n_ttl   = b;
            OFS_PROTO:    n_proto = b;
            default:      ;
        endcase
        if (r_byte_idx >= OFS_SRC && r_byte_idx < OFS_DST) begin
            n_src = {r_src[23:0], b};
        end else if (r_byte_idx >= OFS_DST && r_byte_idx < OFS_HDR_END) begin
            n_dst = {r_dst[23:0], b};
        end
        if (r_byte_idx < hdr_bytes) begin
            if (!r_byte_idx[0]) begin
                n_pend_hi = b;
            end else begin
                n_csum = r_csum + {5'd0, r_pend_hi, b};
            end
        end
        n_byte_idx = (r_byte_idx != BYTE_CNT_MAX) ? r_byte_idx + 16'd1 : r_byte_idx;
    end

    // record of the packet as it stands after this beat
    always_comb begin
        o_rec.received  = n_byte_idx;
        o_rec.ver_ihl   = n_ver_ihl;
        o_rec.total_len = n_total;
        o_rec.flags_ofs = n_flags;
        o_rec.ttl       = n_ttl;
        o_rec.proto     = n_proto;
        o_rec.src_ip    = n_src;
        o_rec.dst_ip    = n_dst;
        o_rec.csum_acc  = n_csum;
    end

    assign o_push = accept && i_byte.last_byte;

    // packet state, cleared after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_idx <= '0;
            r_ver_ihl  <= '0;
            r_total    <= '0;
            r_flags    <= '0;
            r_ttl      <= '0;
            r_proto    <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_csum     <= '0;
            r_pend_hi  <= '0;
        end else if (accept) begin
            r_byte_idx <= n_byte_idx;
            r_ver_ihl  <= n_ver_ihl;
            r_total    <= n_total;
            r_flags    <= n_flags;
            r_ttl      <= n_ttl;
            r_proto    <= n_proto;
            r_src      <= n_src;
            r_dst      <= n_dst;
            r_csum     <= n_csum;
            r_pend_hi  <= n_pend_hi;
        end
    end

endmodule

### hw/rtl/ipv4hv_queue.sv
// ----------------------------------------------------------------------------
// IPv4 header validator record queue
// Two-entry FIFO of header records between front and back.
// ----------------------------------------------------------------------------
`include "ipv4_header_validator_core_macros.svh"

module ipv4hv_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipv4hv_pkg::t_pkt_rec  i_rec,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output ipv4hv_pkg::t_pkt_rec  o_head
);
    import ipv4hv_pkg::*;

    t_pkt_rec    r_entry [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_rec;
        end
    end

    `IPV4HV_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")

endmodule

### hw/rtl/ipv4hv_back.sv
// ----------------------------------------------------------------------------
// IPv4 header validator back end
// Runs the ordered checks on one header record and holds the verdict beat.
// ----------------------------------------------------------------------------
`include "ipv4_header_validator_core_macros.svh"

module ipv4hv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipv4hv_pkg::t_cfg      i_cfg,
    input  logic                  i_q_valid,
    input  ipv4hv_pkg::t_pkt_rec  i_q_head,
    output logic                  o_pop,
    ipv4hv_result_if.source       o_result
);
    import ipv4hv_pkg::*;

    logic        r_valid;
    t_outcome    r_outcome,  n_outcome;
    t_stage      r_stage,    n_stage;
    logic        r_err,      n_err;
    logic [15:0] r_len,      n_len;

    logic [5:0]  ihl_bytes;
    logic [16:0] fold1, fold2;
    logic        hdr_ok, src_ok;
    logic [31:0] net_mask;
    logic [7:0]  src_top;

    // header sanity, including folded checksum
    always_comb begin
        ihl_bytes = {i_q_head.ver_ihl[3:0], 2'b00};
        fold1 = {1'b0, i_q_head.csum_acc[15:0]} + {12'd0, i_q_head.csum_acc[20:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        hdr_ok = (i_q_head.received >= {10'd0, HDR_MIN_BYTES})
              && (i_q_head.ver_ihl[7:4] == IP_VERSION4)
              && (ihl_bytes >= HDR_MIN_BYTES)
              && (i_q_head.total_len >= {10'd0, ihl_bytes})
              && (i_q_head.received >= i_q_head.total_len)
              && (i_q_head.ttl != 8'd0)
              && (fold2 == CSUM_GOOD)
              && !i_q_head.flags_ofs[RSV_FLAG_BIT];
    end

    // source address validity
    always_comb begin
        src_top  = i_q_head.src_ip[31:24];
        net_mask = prefix_mask(i_cfg.subnet_bits);
        src_ok   = !(src_top == NET_ZERO || src_top == NET_LOOPBACK
                  || i_q_head.src_ip >= MCAST_BASE || i_q_head.src_ip == i_cfg.local_ip);
        if (i_cfg.subnet_bits <= MAX_SUBNET_PFX) begin
            if (((i_q_head.src_ip & net_mask) == (i_cfg.local_ip & net_mask))
                && (((i_q_head.src_ip & ~net_mask) == 32'd0)
                    || ((i_q_head.src_ip & ~net_mask) == ~net_mask))) begin
                src_ok = 1'b0;
            end
        end
    end

    // ordered verdict
    always_comb begin
        n_outcome = OUT_FORWARD;
        n_stage   = STG_NONE;
        n_err     = 1'b0;
        n_len     = i_q_head.received;
        if (!hdr_ok) begin
            n_outcome = OUT_INVALID;
            n_err     = 1'b1;
        end else if (i_q_head.dst_ip != i_cfg.local_ip) begin
            n_outcome = OUT_NOT_LOCAL;
        end else if (!src_ok) begin
            n_outcome = OUT_BAD_SRC;
            n_err     = 1'b1;
        end else if (i_q_head.total_len > i_cfg.mtu_limit) begin
            n_outcome = OUT_MTU;
        end else if ((i_q_head.flags_ofs & FRAG_MASK) != 16'd0) begin
            n_outcome = OUT_FRAGMENT;
        end else if (ihl_bytes != HDR_MIN_BYTES) begin
            n_outcome = OUT_OPTIONS;
        end else begin
            unique case (i_q_head.proto)
                PROTO_ICMP: n_stage = STG_ICMP;
                PROTO_UDP:  n_stage = STG_UDP;
                PROTO_TCP:  n_stage = STG_TCP;
                default:    n_outcome = OUT_BAD_PROTO;
            endcase
            if (n_stage != STG_NONE) begin
                n_len = i_q_head.total_len;
            end
        end
    end

    // output register: refill when empty or when the held beat is taken
    assign o_pop = i_q_valid && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_outcome <= n_outcome;
            r_stage   <= n_stage;
            r_err     <= n_err;
            r_len     <= n_len;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.outcome        = r_outcome;
    assign o_result.next_stage     = r_stage;
    assign o_result.count_as_error = r_err;
    assign o_result.forward_length = r_len;

    `IPV4HV_ASSERT_NOW(a_err_class, i_clk, i_rst_n, r_valid, r_err == (r_outcome == OUT_INVALID || r_outcome == OUT_BAD_SRC), "error flag disagrees with outcome")
    `IPV4HV_ASSERT_NOW(a_stage_fwd, i_clk, i_rst_n, r_valid, (r_stage != STG_NONE) == (r_outcome == OUT_FORWARD), "handler set without forward")
    `IPV4HV_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid, "popped record not held")

endmodule
